// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular deque package
// Shared constants, request codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int REQ_W     = 3;
    localparam int CAP_W     = 11;
    localparam int CAP_RESET = 1024;
    localparam int DEPTH_DEF = 1024;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic cfg_write;
        logic load_req;
        logic exec;
        logic read;
        logic load_out;
    } cdq_cmd_t;

endpackage

// ===== sv/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences each request through execute, read and deliver steps.
// ----------------------------------------------------------------------------
module cdq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cdq_pkg::cdq_cmd_t cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   cfg_fire;
    logic   in_fire;
    logic   load_out;

    // Configuration wins over a request offered in the same cycle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cmd.cfg_write = cfg_fire;
    assign cmd.load_req  = in_fire;
    assign cmd.exec      = (state_reg == ST_EXEC);
    assign cmd.read      = (state_reg == ST_READ);
    assign cmd.load_out  = load_out;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted request did not move to execute");

    a_exec_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_READ))
        else $error("execute step not followed by read step");

    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_fire && in_fire))
        else $error("configuration and request transferred together");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== sv/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// Circular deque datapath
// Ring memory, head/tail/count registers, capacity and result register.
// ----------------------------------------------------------------------------
module cdq_datapath
#(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdq_pkg::cdq_cmd_t                 cmd,
    input  logic [cdq_pkg::CAP_W-1:0]         cfg_data,
    input  logic [cdq_pkg::REQ_W-1:0]         req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] value,
    output logic                              ok,
    output logic signed [cdq_pkg::DATA_W-1:0] front_value,
    output logic signed [cdq_pkg::DATA_W-1:0] rear_value,
    output logic                              is_empty,
    output logic                              is_full
);
    import cdq_pkg::*;

    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int CmpW     = (CW > CAP_W) ? CW : CAP_W;
    localparam int ResetCap = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [REQ_W-1:0]  req_reg;
    logic [DATA_W-1:0] value_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     tail_reg;
    logic [AW-1:0]     tail_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     cap_reg;
    logic [CW-1:0]     cap_next;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] front_rd_reg;
    logic [DATA_W-1:0] rear_rd_reg;
    logic              ok_out_reg;
    logic [DATA_W-1:0] front_out_reg;
    logic [DATA_W-1:0] rear_out_reg;
    logic              empty_out_reg;
    logic              full_out_reg;

    logic              full;
    logic              empty;
    logic [AW-1:0]     head_up;
    logic [AW-1:0]     head_dn;
    logic [AW-1:0]     tail_up;
    logic [AW-1:0]     tail_dn;
    logic [AW-1:0]     cap_last;
    logic [CmpW-1:0]   cfg_wide;
    logic [CW-1:0]     cfg_eff;
    logic              we;
    logic [AW-1:0]     waddr;

    assign full     = (count_reg >= cap_reg);
    assign empty    = (count_reg == '0);
    assign cap_last = AW'(cap_reg - CW'(1));
    assign head_up  = ((CW'(head_reg) + CW'(1)) >= cap_reg) ? '0 : AW'(head_reg + AW'(1));
    assign tail_up  = ((CW'(tail_reg) + CW'(1)) >= cap_reg) ? '0 : AW'(tail_reg + AW'(1));
    assign head_dn  = (head_reg == '0) ? cap_last : AW'(head_reg - AW'(1));
    assign tail_dn  = (tail_reg == '0) ? cap_last : AW'(tail_reg - AW'(1));

    // Clamp the written capacity into 1..DEPTH
    assign cfg_wide = CmpW'(cfg_data);
    always_comb
    begin
        if (cfg_wide == '0)
        begin
            cfg_eff = CW'(1);
        end
        else if (cfg_wide > CmpW'(DEPTH))
        begin
            cfg_eff = CW'(DEPTH);
        end
        else
        begin
            cfg_eff = CW'(cfg_wide);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        ok_next    = ok_reg;
        we         = 1'b0;
        waddr      = tail_reg;
        if (cmd.exec)
        begin
            ok_next = 1'b0;
            unique case (req_reg)
                REQ_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        head_next  = head_dn;
                        waddr      = head_dn;
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        tail_next  = tail_up;
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        head_next  = head_up;
                        count_next = count_reg - CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (!empty)
                    begin
                        tail_next  = tail_dn;
                        count_next = count_reg - CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                REQ_QUERY: ok_next = 1'b1;
                default:   ok_next = 1'b0;
            endcase
        end
        // A capacity write also empties the queue
        if (cmd.cfg_write)
        begin
            cap_next   = cfg_eff;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CW'(ResetCap);
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (cmd.load_req)
        begin
            req_reg   <= req_type;
            value_reg <= value;
        end
        if (cmd.load_out)
        begin
            ok_out_reg    <= ok_reg;
            front_out_reg <= empty ? EMPTY_WORD : front_rd_reg;
            rear_out_reg  <= empty ? EMPTY_WORD : rear_rd_reg;
            empty_out_reg <= empty;
            full_out_reg  <= full;
        end
    end

    // Ring memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= value_reg;
        end
        if (cmd.read)
        begin
            front_rd_reg <= mem[head_reg];
            rear_rd_reg  <= mem[tail_dn];
        end
    end

    assign ok          = ok_out_reg;
    assign front_value = front_out_reg;
    assign rear_value  = rear_out_reg;
    assign is_empty    = empty_out_reg;
    assign is_full     = full_out_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("entry count exceeds capacity");

    a_idx_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(head_reg) < cap_reg) && (CW'(tail_reg) < cap_reg))
        else $error("ring index outside capacity");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (we && !cmd.cfg_write) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("store write without count increment");

endmodule

// ===== sv/circular_deque_top.sv =====
// ----------------------------------------------------------------------------
// Circular deque top level
// Double-ended queue in a ring memory with a configurable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel  : cfg_valid/cfg_ready with cfg_data, the 11-bit capacity.
//                  A transfer clamps it into 1..DEPTH and empties the queue.
//                  Write it only while no request is in flight.
//   in channel   : in_valid/in_ready with req_type and value. Codes: push
//                  front, push back, pop front, pop back, query.
//   out channel  : out_valid/out_ready with ok, front_value, rear_value,
//                  is_empty, is_full describing the queue after the request.
//   Sequence     : each accepted request is executed and written, then the
//                  ring is read, then the result is registered; the next
//                  request is accepted only after that, so requests on the
//                  ring memory never overlap.
//   Reset        : queue empty, capacity min(1024, DEPTH); ring contents
//                  undefined, and an unwritten entry is never delivered.
//   Stall        : a held result does not block acceptance of the next
//                  request; that request waits in its final step until the
//                  output register is free.
// ----------------------------------------------------------------------------
module circular_deque_top
#(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cdq_pkg::REQ_W-1:0]         req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic signed [cdq_pkg::DATA_W-1:0] front_value,
    output logic signed [cdq_pkg::DATA_W-1:0] rear_value,
    output logic                              is_empty,
    output logic                              is_full
);
    import cdq_pkg::*;

    cdq_cmd_t cmd;

    // Sequence each request: execute, read, deliver
    cdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Hold ring, indices, capacity and the result register
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .value       (value),
        .ok          (ok),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while one is in flight");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (front_value == EMPTY_WORD && rear_value == EMPTY_WORD
                                     && !is_full))
        else $error("empty result carries data or full flag");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> in_ready || cfg_valid)
        else $error("config ready while request path busy");

endmodule
